[rtl/assert_macros.svh]
// Assertion macros used by the top level of the range allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property at every rising clock edge outside reset.
`define AFF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Checks that a condition in one cycle is followed by another in the next cycle.
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`else
`define AFF_ASSERT(lbl, prop, msg)
`define AFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/aff_pkg.sv]
// Shared types and constants of the aligned first-fit range allocator.
package aff_pkg;

   // Field widths of the streaming ports.
   localparam int SIZE_W      = 41;
   localparam int ALIGN_W     = 33;
   localparam int ROFF_W      = 40;
   localparam int ADDR_W      = 64;
   localparam int STATUS_W    = 3;
   localparam int REQ_FIELD_W = SIZE_W + ALIGN_W + ROFF_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - REQ_FIELD_W;
   localparam int RSP_FIELD_W = STATUS_W + ROFF_W + SIZE_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE  = 1'b1;
   localparam logic [SIZE_W-1:0] REGION_SIZE_RESET = 41'd1048576;

   // Opcodes.
   localparam logic OPC_ALLOCATE = 1'b0;
   localparam logic OPC_RELEASE  = 1'b1;

   // Remainder unit: one quotient bit per cycle.
   localparam int DIV_STEP_W = 6;
   localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = 6'd63;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_BAD_ARG = 3'd1,
      ST_NO_FIT  = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_A_LOAD,
      S_A_START,
      S_A_WAIT,
      S_A_PAD,
      S_A_CHK,
      S_A_FIT,
      S_A_ROT,
      S_A_DECIDE,
      S_R_READ,
      S_R_CMP,
      S_R_PASS,
      S_R_CALC,
      S_R_DECIDE,
      S_EDIT,
      S_EDIT_B,
      S_COMMIT,
      S_FINISH
   } state_type;

   // Command broadcast to the row of free-range cells.
   typedef struct packed {
      logic pop;
      logic push;
   } cell_cmd_type;

endpackage

[rtl/aff_ram.sv]
// Generic single-port-write, registered-read RAM.
module aff_ram #(
   parameter int WIDTH = 81,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                   clock,
   input  logic                   we,
   input  logic [AW-1:0]          waddr,
   input  logic [WIDTH-1:0]       wdata,
   input  logic [AW-1:0]          raddr,
   output logic [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[rtl/aff_div.sv]
// Bit-serial remainder unit: 64-bit dividend by 33-bit divisor.
module aff_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aff_pkg::ADDR_W-1:0]    dividend,
   input  logic [aff_pkg::ALIGN_W-1:0]   divisor,
   output logic                          done,
   output logic [aff_pkg::ALIGN_W-1:0]   remainder
);
   logic [aff_pkg::ADDR_W-1:0]     dvd_ff;
   logic [aff_pkg::ALIGN_W-1:0]    dsr_ff;
   logic [aff_pkg::ALIGN_W-1:0]    rem_ff;
   logic [aff_pkg::ALIGN_W-1:0]    rem_in;
   logic [aff_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic                           run_ff;
   logic                           done_ff;
   logic [aff_pkg::ALIGN_W:0]      trial;
   logic [aff_pkg::ALIGN_W+1:0]    diff;

   // One restoring step: shift in the next dividend bit, subtract if possible.
   always_comb begin
      trial  = {rem_ff, dvd_ff[aff_pkg::ADDR_W-1]};
      diff   = {1'b0, trial} - {2'b00, dsr_ff};
      rem_in = diff[aff_pkg::ALIGN_W+1] ? trial[aff_pkg::ALIGN_W-1:0]
                                        : diff[aff_pkg::ALIGN_W-1:0];
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == aff_pkg::DIV_LAST_STEP) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Operand and partial remainder registers.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         dvd_ff <= {dvd_ff[aff_pkg::ADDR_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
endmodule

[rtl/aff_cell.sv]
// One cell of the free-range row: holds one (offset, length) entry.
module aff_cell #(
   parameter int OFF_W = 40,
   parameter int LEN_W = 41,
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic                  clock,
   input  aff_pkg::cell_cmd_type cmd,
   input  logic [CNT_W-1:0]      wpos,
   input  logic [OFF_W-1:0]      new_off,
   input  logic [LEN_W-1:0]      new_len,
   input  logic [OFF_W-1:0]      right_off,
   input  logic [LEN_W-1:0]      right_len,
   output logic [OFF_W-1:0]      off,
   output logic [LEN_W-1:0]      len
);
   logic [OFF_W-1:0] off_ff;
   logic [LEN_W-1:0] len_ff;

   // Load at the write position, otherwise take the right neighbor on a pop.
   always_ff @(posedge clock) begin
      if (cmd.push && (wpos == CNT_W'(IDX))) begin
         off_ff <= new_off;
         len_ff <= new_len;
      end else if (cmd.pop) begin
         off_ff <= right_off;
         len_ff <= right_len;
      end
   end

   assign off = off_ff;
   assign len = len_ff;
endmodule

[rtl/aligned_first_fit_range_allocator_unit.sv]
// Top level of the aligned first-fit range allocator with coalescing.
// Allocate: each free range examined waits on the bit-serial remainder unit, the ranges
// after the fit are rotated through, then the table is updated (a further write on a split).
// Release: a RAM read per allocation slot searched, then a range pass and a table update.
// Reset (synchronous): base 0, region 1 MiB, one free range, no allocations.
module aligned_first_fit_range_allocator_unit #(
   parameter int MAX_FREE_RANGES = 64,
   parameter int MAX_ALLOCATIONS = 64,
   parameter int OFFSET_BITS     = 40
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Request: tdata = req_size, req_alignment, release_offset (low bit up).
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [aff_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // Request: tuser = opcode.
   input  logic                                 req_tuser,
   // Response: tdata = status, slice_offset, slice_size (low bit up).
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [aff_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // Configuration write port.
   input  logic                                 csr_we,
   input  logic [aff_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [aff_pkg::CSR_DATA_W-1:0]       csr_wdata
);
`include "assert_macros.svh"

   localparam int OB  = OFFSET_BITS;
   localparam int LW  = OFFSET_BITS + 1;
   localparam int MF  = MAX_FREE_RANGES;
   localparam int MA  = MAX_ALLOCATIONS;
   localparam int CW  = $clog2(MAX_FREE_RANGES + 1);
   localparam int AW  = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
   localparam int ACW = $clog2(MAX_ALLOCATIONS + 1);
   localparam int AXW = aff_pkg::ADDR_W;

   // Clamp a region size to the offset space.
   function automatic logic [LW-1:0] clamp_region(input logic [aff_pkg::SIZE_W-1:0] r);
      logic [AXW-1:0] lim;
      lim = AXW'(1) << OB;
      if (AXW'(r) > lim) begin
         clamp_region = LW'(lim);
      end else begin
         clamp_region = LW'(r);
      end
   endfunction

   aff_pkg::state_type state_ff, state_in;

   // Request fields and configuration.
   logic                          opc_ff;
   logic [aff_pkg::SIZE_W-1:0]    size_ff;
   logic [aff_pkg::ALIGN_W-1:0]   align_ff;
   logic [aff_pkg::ROFF_W-1:0]    roff_ff;
   logic [AXW-1:0]                base_ff;
   logic [aff_pkg::SIZE_W-1:0]    region_ff;

   // Table bookkeeping.
   logic [CW-1:0]   fcount_ff, j_ff, n_ff, e_ff, p_ff, fidx_ff;
   logic [ACW-1:0]  acount_ff;
   logic [MA-1:0]   avalid_ff;
   logic [AW-1:0]   k_ff, aslot_ff, free_slot;

   // Scan datapath.
   logic [AXW-1:0]              addr_ff, remlen_ff;
   logic [aff_pkg::ALIGN_W-1:0] pad_ff;
   logic                        ovf_ff, padle_ff, found_ff;
   logic [OB-1:0]               begin_ff;
   logic [LW-1:0]               len_ff, start_ff, end_ff, rend_ff;
   logic                        pfound_ff, mprev_ff, mnext_ff;
   logic [OB-1:0]               prev_off_ff, nxt_off_ff;
   logic [LW-1:0]               prev_len_ff, nxt_len_ff, sum1_ff;

   // Edit descriptor for the second pass.
   logic          pre_en_ff, pre_done_ff, drop_prev_ff, mod_en_ff, a_en_ff, b_en_ff;
   logic [OB-1:0] a_off_ff, b_off_ff;
   logic [LW-1:0] a_len_ff, b_len_ff;

   // Result.
   aff_pkg::status_type          st_ff;
   logic [aff_pkg::ROFF_W-1:0]   res_off_ff;
   logic [aff_pkg::SIZE_W-1:0]   res_len_ff;
   logic                         rsp_valid_ff;
   logic [aff_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   // Cell row.
   aff_pkg::cell_cmd_type cmd;
   logic [CW-1:0]  wpos;
   logic [OB-1:0]  new_off;
   logic [LW-1:0]  new_len;
   logic [OB-1:0]  cell_off [MF];
   logic [LW-1:0]  cell_len [MF];
   logic [OB-1:0]  head_off;
   logic [LW-1:0]  head_len;

   // Remainder unit and allocation RAM.
   logic                        div_start, div_done;
   logic [aff_pkg::ALIGN_W-1:0] div_rem;
   logic                        ram_we;
   logic [AW-1:0]               ram_raddr;
   logic [OB+LW-1:0]            ram_rdata;
   logic [OB-1:0]               rd_off;
   logic [LW-1:0]               rd_len;

   // Second-pass step kinds.
   logic ed_pre, ed_end, ed_drop, ed_mod;
   logic init_tables;
   logic [LW-1:0] init_len;
   logic out_free;

   assign head_off = cell_off[0];
   assign head_len = cell_len[0];
   assign rd_off   = ram_rdata[OB-1:0];
   assign rd_len   = ram_rdata[OB+LW-1:OB];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // Tables return to one free range (none if the region size is zero) on reset and on every register write.
   assign init_tables = reset || csr_we;
   always_comb begin
      if (reset) begin
         init_len = clamp_region(aff_pkg::REGION_SIZE_RESET);
      end else if (csr_index == aff_pkg::CSR_REGION_SIZE) begin
         init_len = clamp_region(csr_wdata[aff_pkg::SIZE_W-1:0]);
      end else begin
         init_len = clamp_region(region_ff);
      end
   end

   // First free allocation slot.
   always_comb begin
      free_slot = '0;
      for (int i = MA - 1; i >= 0; i--) begin
         if (!avalid_ff[i]) begin
            free_slot = AW'(i);
         end
      end
   end

   // Step kinds of the table-update pass.
   always_comb begin
      ed_pre  = pre_en_ff && !pre_done_ff && (j_ff == e_ff);
      ed_end  = !ed_pre && (j_ff == n_ff);
      ed_drop = !ed_pre && !ed_end && drop_prev_ff && ((j_ff + 1'b1) == e_ff);
      ed_mod  = !ed_pre && !ed_end && !ed_drop && mod_en_ff && (j_ff == e_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         aff_pkg::S_IDLE:    if (req_tvalid) state_in = aff_pkg::S_CHECK;
         aff_pkg::S_CHECK: begin
            if (opc_ff == aff_pkg::OPC_RELEASE) begin
               state_in = aff_pkg::S_R_READ;
            end else if (size_ff == '0 || align_ff == '0 || acount_ff >= ACW'(MA)) begin
               state_in = aff_pkg::S_FINISH;
            end else begin
               state_in = aff_pkg::S_A_LOAD;
            end
         end
         aff_pkg::S_A_LOAD:  state_in = (j_ff == n_ff) ? aff_pkg::S_A_DECIDE
                                                       : aff_pkg::S_A_START;
         aff_pkg::S_A_START: state_in = aff_pkg::S_A_WAIT;
         aff_pkg::S_A_WAIT:  if (div_done) state_in = aff_pkg::S_A_PAD;
         aff_pkg::S_A_PAD:   state_in = aff_pkg::S_A_CHK;
         aff_pkg::S_A_CHK:   state_in = aff_pkg::S_A_FIT;
         aff_pkg::S_A_FIT: begin
            if (!ovf_ff && padle_ff && (AXW'(size_ff) <= remlen_ff)) begin
               state_in = aff_pkg::S_A_ROT;
            end else begin
               state_in = aff_pkg::S_A_LOAD;
            end
         end
         aff_pkg::S_A_ROT:   if (j_ff == n_ff) state_in = aff_pkg::S_A_DECIDE;
         aff_pkg::S_A_DECIDE: begin
            if (!found_ff) begin
               state_in = aff_pkg::S_FINISH;
            end else if (pad_ff != '0 && end_ff != rend_ff && fcount_ff >= CW'(MF)) begin
               state_in = aff_pkg::S_FINISH;
            end else begin
               state_in = aff_pkg::S_EDIT;
            end
         end
         aff_pkg::S_R_READ:  state_in = aff_pkg::S_R_CMP;
         aff_pkg::S_R_CMP: begin
            if (avalid_ff[k_ff] && (AXW'(rd_off) == AXW'(roff_ff))) begin
               state_in = aff_pkg::S_R_PASS;
            end else if (k_ff == AW'(MA - 1)) begin
               state_in = aff_pkg::S_FINISH;
            end else begin
               state_in = aff_pkg::S_R_READ;
            end
         end
         aff_pkg::S_R_PASS:  if (j_ff == n_ff) state_in = aff_pkg::S_R_CALC;
         aff_pkg::S_R_CALC:  state_in = aff_pkg::S_R_DECIDE;
         aff_pkg::S_R_DECIDE: begin
            if (!mprev_ff && !mnext_ff && fcount_ff >= CW'(MF)) begin
               state_in = aff_pkg::S_FINISH;
            end else begin
               state_in = aff_pkg::S_EDIT;
            end
         end
         aff_pkg::S_EDIT: begin
            if (ed_end) begin
               state_in = aff_pkg::S_COMMIT;
            end else if (ed_mod && b_en_ff) begin
               state_in = aff_pkg::S_EDIT_B;
            end
         end
         aff_pkg::S_EDIT_B:  state_in = aff_pkg::S_EDIT;
         aff_pkg::S_COMMIT:  state_in = aff_pkg::S_FINISH;
         aff_pkg::S_FINISH:  if (out_free) state_in = aff_pkg::S_IDLE;
         default:            state_in = aff_pkg::S_IDLE;
      endcase
   end

   // Outputs to the cell row, the remainder unit and the RAM.
   always_comb begin
      cmd       = '0;
      new_off   = head_off;
      new_len   = head_len;
      div_start = (state_ff == aff_pkg::S_A_START);
      ram_we    = (state_ff == aff_pkg::S_COMMIT) && (opc_ff == aff_pkg::OPC_ALLOCATE);
      ram_raddr = k_ff;
      if (init_tables) begin
         cmd.push = 1'b1;
         new_off  = '0;
         new_len  = init_len;
      end else begin
         unique case (state_ff)
            aff_pkg::S_A_FIT: begin
               cmd.pop  = 1'b1;
               cmd.push = 1'b1;
            end
            aff_pkg::S_A_ROT, aff_pkg::S_R_PASS: begin
               cmd.pop  = (j_ff != n_ff);
               cmd.push = (j_ff != n_ff);
            end
            aff_pkg::S_EDIT: begin
               if (ed_pre) begin
                  cmd.push = 1'b1;
                  new_off  = a_off_ff;
                  new_len  = a_len_ff;
               end else if (ed_drop) begin
                  cmd.pop = 1'b1;
               end else if (ed_mod) begin
                  cmd.pop  = 1'b1;
                  cmd.push = a_en_ff;
                  new_off  = a_off_ff;
                  new_len  = a_len_ff;
               end else if (!ed_end) begin
                  cmd.pop  = 1'b1;
                  cmd.push = 1'b1;
               end
            end
            aff_pkg::S_EDIT_B: begin
               cmd.push = 1'b1;
               new_off  = b_off_ff;
               new_len  = b_len_ff;
            end
            default: ;
         endcase
      end
      if (init_tables) begin
         wpos = '0;
      end else if (cmd.pop) begin
         wpos = fcount_ff - 1'b1;
      end else begin
         wpos = fcount_ff;
      end
   end

   assign req_tready = (state_ff == aff_pkg::S_IDLE);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aff_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         region_ff    <= aff_pkg::REGION_SIZE_RESET;
         fcount_ff    <= (init_len != '0) ? CW'(1) : '0;
         acount_ff    <= '0;
         avalid_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == aff_pkg::S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end
         if (csr_we) begin
            if (csr_index == aff_pkg::CSR_BASE_ADDRESS) begin
               base_ff <= csr_wdata;
            end else begin
               region_ff <= csr_wdata[aff_pkg::SIZE_W-1:0];
            end
            fcount_ff <= (init_len != '0) ? CW'(1) : '0;
            acount_ff <= '0;
            avalid_ff <= '0;
         end else begin
            if (cmd.pop && !cmd.push) begin
               fcount_ff <= fcount_ff - 1'b1;
            end else if (cmd.push && !cmd.pop) begin
               fcount_ff <= fcount_ff + 1'b1;
            end
            if (state_ff == aff_pkg::S_COMMIT) begin
               if (opc_ff == aff_pkg::OPC_ALLOCATE) begin
                  avalid_ff[free_slot] <= 1'b1;
                  acount_ff            <= acount_ff + 1'b1;
               end else begin
                  avalid_ff[aslot_ff] <= 1'b0;
                  acount_ff           <= acount_ff - 1'b1;
               end
            end
         end
      end
   end

   // Datapath registers, sequenced by the state.
   always_ff @(posedge clock) begin
      if (state_ff == aff_pkg::S_FINISH && out_free) begin
         rsp_data_ff <= {{aff_pkg::RSP_PAD_W{1'b0}}, res_len_ff, res_off_ff, st_ff};
      end
      if (cmd.pop || cmd.push) begin
         if (state_ff != aff_pkg::S_EDIT && state_ff != aff_pkg::S_EDIT_B) begin
            j_ff <= j_ff + 1'b1;
         end else if (!ed_pre && state_ff == aff_pkg::S_EDIT) begin
            j_ff <= j_ff + 1'b1;
         end
      end
      unique case (state_ff)
         aff_pkg::S_IDLE: begin
            opc_ff     <= req_tuser;
            size_ff    <= req_tdata[aff_pkg::SIZE_W-1:0];
            align_ff   <= req_tdata[aff_pkg::SIZE_W+aff_pkg::ALIGN_W-1:aff_pkg::SIZE_W];
            roff_ff    <= req_tdata[aff_pkg::REQ_FIELD_W-1:aff_pkg::SIZE_W+aff_pkg::ALIGN_W];
            res_off_ff <= '0;
            res_len_ff <= '0;
            st_ff      <= aff_pkg::ST_OK;
         end
         aff_pkg::S_CHECK: begin
            j_ff     <= '0;
            n_ff     <= fcount_ff;
            k_ff     <= '0;
            found_ff <= 1'b0;
            if (opc_ff == aff_pkg::OPC_ALLOCATE) begin
               if (size_ff == '0 || align_ff == '0) begin
                  st_ff <= aff_pkg::ST_BAD_ARG;
               end else if (acount_ff >= ACW'(MA)) begin
                  st_ff <= aff_pkg::ST_FULL;
               end
            end
         end
         aff_pkg::S_A_LOAD: begin
            begin_ff <= head_off;
            len_ff   <= head_len;
            addr_ff  <= base_ff + AXW'(head_off);
         end
         aff_pkg::S_A_PAD: begin
            pad_ff <= (div_rem == '0) ? '0 : (align_ff - div_rem);
         end
         aff_pkg::S_A_CHK: begin
            ovf_ff    <= ({1'b0, addr_ff} + (AXW + 1)'(pad_ff)) > (AXW + 1)'({AXW{1'b1}});
            padle_ff  <= AXW'(pad_ff) <= AXW'(len_ff);
            remlen_ff <= AXW'(len_ff) - AXW'(pad_ff);
            start_ff  <= LW'(AXW'(begin_ff) + AXW'(pad_ff));
            rend_ff   <= LW'(begin_ff) + len_ff;
         end
         aff_pkg::S_A_FIT: begin
            end_ff <= start_ff + LW'(size_ff);
            if (!ovf_ff && padle_ff && (AXW'(size_ff) <= remlen_ff)) begin
               found_ff <= 1'b1;
               fidx_ff  <= j_ff;
            end
         end
         aff_pkg::S_A_DECIDE: begin
            pre_en_ff    <= 1'b0;
            pre_done_ff  <= 1'b0;
            drop_prev_ff <= 1'b0;
            mod_en_ff    <= 1'b1;
            e_ff         <= fidx_ff;
            j_ff         <= '0;
            a_en_ff      <= (pad_ff != '0) || (end_ff != rend_ff);
            b_en_ff      <= (pad_ff != '0) && (end_ff != rend_ff);
            b_off_ff     <= OB'(end_ff);
            b_len_ff     <= rend_ff - end_ff;
            if (pad_ff != '0) begin
               a_off_ff <= begin_ff;
               a_len_ff <= LW'(pad_ff);
            end else begin
               a_off_ff <= OB'(end_ff);
               a_len_ff <= rend_ff - end_ff;
            end
            if (!found_ff) begin
               st_ff <= aff_pkg::ST_NO_FIT;
            end else if (pad_ff != '0 && end_ff != rend_ff && fcount_ff >= CW'(MF)) begin
               st_ff <= aff_pkg::ST_FULL;
            end
         end
         aff_pkg::S_R_CMP: begin
            begin_ff  <= rd_off;
            len_ff    <= rd_len;
            aslot_ff  <= k_ff;
            j_ff      <= '0;
            p_ff      <= fcount_ff;
            pfound_ff <= 1'b0;
            k_ff      <= k_ff + 1'b1;
            if (!(avalid_ff[k_ff] && (AXW'(rd_off) == AXW'(roff_ff))) &&
                k_ff == AW'(MA - 1)) begin
               st_ff <= aff_pkg::ST_UNKNOWN;
            end
         end
         aff_pkg::S_R_PASS: begin
            if (j_ff != n_ff && !pfound_ff) begin
               if (head_off >= begin_ff) begin
                  pfound_ff  <= 1'b1;
                  p_ff       <= j_ff;
                  nxt_off_ff <= head_off;
                  nxt_len_ff <= head_len;
               end else begin
                  prev_off_ff <= head_off;
                  prev_len_ff <= head_len;
               end
            end
         end
         aff_pkg::S_R_CALC: begin
            mprev_ff <= (p_ff != '0) && ((LW'(prev_off_ff) + prev_len_ff) == LW'(begin_ff));
            mnext_ff <= pfound_ff && ((LW'(begin_ff) + len_ff) == LW'(nxt_off_ff));
            sum1_ff  <= prev_len_ff + len_ff;
         end
         aff_pkg::S_R_DECIDE: begin
            pre_done_ff  <= 1'b0;
            j_ff         <= '0;
            a_en_ff      <= 1'b1;
            b_en_ff      <= 1'b0;
            pre_en_ff    <= !mprev_ff && !mnext_ff;
            drop_prev_ff <= mprev_ff && mnext_ff;
            mod_en_ff    <= mprev_ff || mnext_ff;
            if (mprev_ff && !mnext_ff) begin
               e_ff <= p_ff - 1'b1;
            end else begin
               e_ff <= p_ff;
            end
            if (mprev_ff) begin
               a_off_ff <= prev_off_ff;
               a_len_ff <= mnext_ff ? (sum1_ff + nxt_len_ff) : sum1_ff;
            end else begin
               a_off_ff <= begin_ff;
               a_len_ff <= mnext_ff ? (len_ff + nxt_len_ff) : len_ff;
            end
            if (!mprev_ff && !mnext_ff && fcount_ff >= CW'(MF)) begin
               st_ff <= aff_pkg::ST_FULL;
            end
         end
         aff_pkg::S_EDIT: begin
            if (ed_pre) begin
               pre_done_ff <= 1'b1;
            end
         end
         aff_pkg::S_COMMIT: begin
            if (opc_ff == aff_pkg::OPC_ALLOCATE) begin
               res_off_ff <= aff_pkg::ROFF_W'(start_ff);
               res_len_ff <= size_ff;
            end else begin
               res_off_ff <= roff_ff;
               res_len_ff <= aff_pkg::SIZE_W'(len_ff);
            end
         end
         default: ;
      endcase
   end

   // Row of free-range cells, each shifting toward the head on a pop.
   for (genvar c = 0; c < MF; c++) begin : g_cell
      logic [OB-1:0] r_off;
      logic [LW-1:0] r_len;
      if (c == MF - 1) begin : g_last
         assign r_off = '0;
         assign r_len = '0;
      end else begin : g_mid
         assign r_off = cell_off[c+1];
         assign r_len = cell_len[c+1];
      end
      aff_cell #(
         .OFF_W(OB),
         .LEN_W(LW),
         .CNT_W(CW),
         .IDX  (c)
      ) u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .wpos     (wpos),
         .new_off  (new_off),
         .new_len  (new_len),
         .right_off(r_off),
         .right_len(r_len),
         .off      (cell_off[c]),
         .len      (cell_len[c])
      );
   end

   // Remainder of the absolute address by the alignment.
   aff_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (addr_ff),
      .divisor  (align_ff),
      .done     (div_done),
      .remainder(div_rem)
   );

   // Live allocations: offset in the low bits, size above.
   aff_ram #(
      .WIDTH(OB + LW),
      .DEPTH(MA)
   ) u_alloc_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(free_slot),
      .wdata({LW'(size_ff), OB'(start_ff)}),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on table counts, error results and request sequencing.
   `AFF_ASSERT(a_fcount_range, fcount_ff <= CW'(MF), "free range count exceeds table depth")
   `AFF_ASSERT(a_acount_range, acount_ff <= ACW'(MA), "allocation count exceeds table depth")
   `AFF_ASSERT(a_err_zero, (st_ff == aff_pkg::ST_OK) || (res_off_ff == '0 && res_len_ff == '0), "error result carries nonzero payload")
   `AFF_ASSERT_NEXT(a_req_busy, req_tvalid && req_tready, state_ff != aff_pkg::S_IDLE, "request transfer did not start work")
endmodule
